// ===== hdl/tlbc_pkg.sv =====
// Package for the tower lamp blink controller.
// Holds the status codes, lamp bit positions, mode codes, register indexes and beat types.
// No dependencies.
`timescale 1ns / 1ps

package tlbc_pkg;

	// Machine status encoding, shared by run_status and shown_status.
	localparam logic [2:0] ST_STOP      = 3'd0;
	localparam logic [2:0] ST_RUN       = 3'd1;
	localparam logic [2:0] ST_JAM       = 3'd2;
	localparam logic [2:0] ST_LOTEND    = 3'd3;
	localparam logic [2:0] ST_INIT      = 3'd4;
	localparam logic [2:0] ST_WARNING   = 3'd5;
	localparam logic [2:0] ST_LOCK      = 3'd6;
	localparam logic [2:0] ST_SELFCHECK = 3'd7;

	// Bit positions in the lamp level vector.
	localparam int LAMP_RED    = 0;
	localparam int LAMP_YELLOW = 1;
	localparam int LAMP_GREEN  = 2;
	localparam int LAMP_START  = 3;
	localparam int LAMP_STOP   = 4;
	localparam int LAMP_CLEAR  = 5;
	localparam int LAMP_COUNT  = 6;

	// Two-bit lamp mode codes in the mode tables.
	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_ON      = 2'd1;
	localparam logic [1:0] MODE_FLICKER = 2'd2;
	localparam logic [1:0] MODE_KEEP    = 2'd3;

	// Blink phases. Even phases set lamps, odd phases wait.
	localparam logic [2:0] PH_ON       = 3'd0;
	localparam logic [2:0] PH_ON_WAIT  = 3'd1;
	localparam logic [2:0] PH_OFF      = 3'd2;
	localparam logic [2:0] PH_OFF_WAIT = 3'd3;
	localparam logic [2:0] PH_CHASE_G  = 3'd4;
	localparam logic [2:0] PH_CHASE_Y2 = 3'd6;

	// Configuration register indexes (byte address divided by four).
	localparam logic [1:0] REG_RED_MODES    = 2'd0;
	localparam logic [1:0] REG_GREEN_MODES  = 2'd1;
	localparam logic [1:0] REG_YELLOW_MODES = 2'd2;
	localparam logic [1:0] REG_WAIT_TICKS   = 2'd3;

	localparam int          TABLE_WIDTH = 16;
	localparam logic [15:0] WAIT_RESET  = 16'd500;

	typedef struct packed {
		logic [2:0] run_status;
		logic       io_screen;
		logic       recovery;
		logic       lot_end;
		logic       lot_empty;
		logic       next_down;
	} item_t;

	typedef struct packed {
		logic [LAMP_COUNT-1:0] lamps;
		logic [2:0]            shown_status;
	} result_t;

	typedef struct packed {
		logic [TABLE_WIDTH-1:0] red;
		logic [TABLE_WIDTH-1:0] green;
		logic [TABLE_WIDTH-1:0] yellow;
	} modes_t;

endpackage

// ===== hdl/tlbc_item_if.sv =====
// Input channel of the tower lamp blink controller: one tick with status and flags per beat.
// No dependencies.
`timescale 1ns / 1ps

interface tlbc_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] run_status;
	logic       io_screen;
	logic       recovery;
	logic       lot_end;
	logic       lot_empty;
	logic       next_down;

	modport source (output valid, run_status, io_screen, recovery, lot_end, lot_empty,
		next_down, input ready);
	modport sink (input valid, run_status, io_screen, recovery, lot_end, lot_empty,
		next_down, output ready);
endinterface

// ===== hdl/tlbc_result_if.sv =====
// Output channel of the tower lamp blink controller: lamp levels and shown status per beat.
// No dependencies.
`timescale 1ns / 1ps

interface tlbc_result_if;
	logic       valid;
	logic       ready;
	logic       red_lamp;
	logic       yellow_lamp;
	logic       green_lamp;
	logic       start_lamp;
	logic       stop_lamp;
	logic       clear_lamp;
	logic [2:0] shown_status;

	modport source (output valid, red_lamp, yellow_lamp, green_lamp, start_lamp, stop_lamp,
		clear_lamp, shown_status, input ready);
	modport sink (input valid, red_lamp, yellow_lamp, green_lamp, start_lamp, stop_lamp,
		clear_lamp, shown_status, output ready);
endinterface

// ===== hdl/tlbc_core.sv =====
// Lamp state registers and the per-tick update logic of the tower lamp blink controller.
// Depends on tlbc_pkg.
`timescale 1ns / 1ps

module tlbc_core import tlbc_pkg::*; #(
	parameter int WAIT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  item_t                 item,
	input  modes_t                modes,
	input  logic [TABLE_WIDTH-1:0] wait_ticks,
	output result_t               next_result
);

	localparam int EW = WAIT_WIDTH + 1;

	logic [2:0]            phase_q;
	logic [EW-1:0]         elapsed_q;
	logic [LAMP_COUNT-1:0] lamps_q;
	logic [2:0]            shown_q;

	logic [2:0]            phase_d;
	logic [EW-1:0]         elapsed_d;
	logic [LAMP_COUNT-1:0] lamps_d;
	logic [2:0]            shown_d;

	logic [EW-1:0] wait_eff;
	logic [EW-1:0] elapsed_inc;
	logic          wait_over;
	logic [1:0]    red_mode;
	logic [1:0]    green_mode;
	logic [1:0]    yellow_mode;
	logic          flick_on;

	// The wait register is masked to WAIT_WIDTH bits before the compare.
	genvar gi;
	generate
		for (gi = 0; gi < EW; gi++) begin : g_wait
			if (gi < WAIT_WIDTH && gi < TABLE_WIDTH) begin : g_bit
				assign wait_eff[gi] = wait_ticks[gi];
			end else begin : g_zero
				assign wait_eff[gi] = 1'b0;
			end
		end
	endgenerate

	// The elapsed count saturates instead of wrapping.
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + EW'(1);
	assign wait_over   = elapsed_inc > wait_eff;

	function automatic logic apply_mode(input logic [1:0] mode, input logic level,
		input logic flick);
		logic res;
		res = level;
		case (mode)
			MODE_OFF:     res = 1'b0;
			MODE_ON:      res = 1'b1;
			MODE_FLICKER: res = flick;
			MODE_KEEP:    res = level;
			default:      res = level;
		endcase
		return res;
	endfunction

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		lamps_d   = lamps_q;
		shown_d   = shown_q;
		flick_on  = (phase_q == PH_ON);
		red_mode    = 2'd0;
		green_mode  = 2'd0;
		yellow_mode = 2'd0;

		if (!item.io_screen) begin
			if (item.run_status == ST_JAM || item.run_status == ST_WARNING) begin
				lamps_d[LAMP_STOP]  = 1'b1;
				lamps_d[LAMP_START] = 1'b0;
			end

			if (item.run_status == ST_INIT) begin
				// Eight-phase chase: red, yellow, green, yellow with a wait after each.
				if (!phase_q[0]) begin
					lamps_d[LAMP_RED]    = (phase_q == PH_ON);
					lamps_d[LAMP_START]  = (phase_q == PH_ON);
					lamps_d[LAMP_YELLOW] = (phase_q == PH_OFF) || (phase_q == PH_CHASE_Y2);
					lamps_d[LAMP_STOP]   = (phase_q == PH_OFF) || (phase_q == PH_CHASE_Y2);
					lamps_d[LAMP_GREEN]  = (phase_q == PH_CHASE_G);
					lamps_d[LAMP_CLEAR]  = (phase_q == PH_CHASE_G);
					elapsed_d = '0;
					phase_d   = phase_q + 3'd1;
				end else begin
					elapsed_d = elapsed_inc;
					if (wait_over) begin
						phase_d = phase_q + 3'd1;
					end
				end
			end else begin
				if (!item.recovery) begin
					if (item.lot_end) begin
						shown_d = ST_LOTEND;
					end else if (item.lot_empty || item.next_down) begin
						shown_d = ST_SELFCHECK;
					end else begin
						shown_d = item.run_status;
					end
				end
				red_mode    = modes.red[{shown_d, 1'b0} +: 2];
				green_mode  = modes.green[{shown_d, 1'b0} +: 2];
				yellow_mode = modes.yellow[{shown_d, 1'b0} +: 2];

				if (phase_q[2]) begin
					phase_d = PH_ON;
				end else if (!phase_q[0]) begin
					if (item.recovery) begin
						lamps_d[LAMP_GREEN] = flick_on;
						lamps_d[LAMP_START] = flick_on;
					end else begin
						lamps_d[LAMP_RED]    = apply_mode(red_mode, lamps_d[LAMP_RED], flick_on);
						lamps_d[LAMP_GREEN]  = apply_mode(green_mode, lamps_d[LAMP_GREEN],
							flick_on);
						lamps_d[LAMP_YELLOW] = apply_mode(yellow_mode, lamps_d[LAMP_YELLOW],
							flick_on);
					end
					elapsed_d = '0;
					phase_d   = phase_q + 3'd1;
				end else begin
					elapsed_d = elapsed_inc;
					if (wait_over) begin
						phase_d = (phase_q == PH_OFF_WAIT) ? PH_ON : PH_OFF;
					end
				end
			end
		end
	end

	assign next_result.lamps        = lamps_d;
	assign next_result.shown_status = shown_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ON;
			elapsed_q <= '0;
			lamps_q   <= '0;
			shown_q   <= ST_STOP;
		end else if (step) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			lamps_q   <= lamps_d;
			shown_q   <= shown_d;
		end
	end

	// A frozen tick leaves every piece of state alone.
	a_frozen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.io_screen) |=> ($stable(lamps_q) && $stable(phase_q) &&
		$stable(elapsed_q) && $stable(shown_q)))
		else $error("state changed on a frozen tick");

	// Outside the init chase the blink cycle stays within its four phases.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.io_screen && item.run_status != ST_INIT) |=> (phase_q[2] == 1'b0))
		else $error("blink phase out of range");

	// A lamp-setting phase restarts the wait count.
	a_elapsed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.io_screen && !phase_q[0] &&
		(item.run_status == ST_INIT || !phase_q[2])) |=> (elapsed_q == '0))
		else $error("elapsed count not cleared");

	// Jam and warning always leave the stop lamp lit.
	a_stop_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.io_screen &&
		(item.run_status == ST_JAM || item.run_status == ST_WARNING)) |=> lamps_q[LAMP_STOP])
		else $error("stop lamp dark on jam or warning");

endmodule

// ===== hdl/tower_lamp_blink_controller.sv =====
// Top level of the tower lamp blink controller: channel registers and the APB register file.
// Depends on tlbc_pkg, tlbc_item_if, tlbc_result_if and tlbc_core.
//
// Usage:
// Each beat on the item channel is one millisecond tick carrying the machine status and flags.
// For every tick the block returns exactly one beat on the result channel with the six lamp
// levels after that tick and the display status chosen by priority.
// The tick enters an input register; the update logic sits between that register and the
// result register, and each result beat is registered there after its tick leaves the input
// register. One tick is taken every cycle as long as the result channel drains; the lamp
// registers update from combinational next-state logic on each step, which sets that rate.
// When the receiver stalls, the result register holds its beat and the input register holds
// the next tick; the item channel then stalls until the result beat is taken.
// Reset clears all lamps, the blink phase, the elapsed count and the shown status; the mode
// tables reset to zero and the phase length to 500 ticks. The user must write registers over
// APB at byte addresses 0, 4, 8 and 12 only while no tick is in flight; it is not enforced.
`timescale 1ns / 1ps

module tower_lamp_blink_controller import tlbc_pkg::*; #(
	parameter int WAIT_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	tlbc_item_if.sink    item,
	tlbc_result_if.source result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic                   s1_valid_q;
	item_t                  item_s1;
	logic                   res_valid_q;
	result_t                result_s2;
	result_t                next_result;
	logic                   advance;
	logic                   accept;
	logic                   cfg_write;
	modes_t                 modes_q;
	logic [TABLE_WIDTH-1:0] wait_q;
	logic [1:0]             reg_index;

	assign advance    = s1_valid_q && (!res_valid_q || result.ready);
	assign item.ready = !s1_valid_q || advance;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.run_status <= item.run_status;
			item_s1.io_screen  <= item.io_screen;
			item_s1.recovery   <= item.recovery;
			item_s1.lot_end    <= item.lot_end;
			item_s1.lot_empty  <= item.lot_empty;
			item_s1.next_down  <= item.next_down;
		end
		if (advance) begin
			result_s2 <= next_result;
		end
	end

	tlbc_core #(
		.WAIT_WIDTH (WAIT_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.modes       (modes_q),
		.wait_ticks  (wait_q),
		.next_result (next_result)
	);

	assign result.valid        = res_valid_q;
	assign result.red_lamp     = result_s2.lamps[LAMP_RED];
	assign result.yellow_lamp  = result_s2.lamps[LAMP_YELLOW];
	assign result.green_lamp   = result_s2.lamps[LAMP_GREEN];
	assign result.start_lamp   = result_s2.lamps[LAMP_START];
	assign result.stop_lamp    = result_s2.lamps[LAMP_STOP];
	assign result.clear_lamp   = result_s2.lamps[LAMP_CLEAR];
	assign result.shown_status = result_s2.shown_status;

	// Register file. The two low address bits select bytes and are ignored.
	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q <= '0;
			wait_q  <= WAIT_RESET;
		end else if (cfg_write) begin
			case (reg_index)
				REG_RED_MODES:    modes_q.red    <= pwdata[TABLE_WIDTH-1:0];
				REG_GREEN_MODES:  modes_q.green  <= pwdata[TABLE_WIDTH-1:0];
				REG_YELLOW_MODES: modes_q.yellow <= pwdata[TABLE_WIDTH-1:0];
				REG_WAIT_TICKS:   wait_q         <= pwdata[TABLE_WIDTH-1:0];
				default:          wait_q         <= wait_q;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_RED_MODES:    prdata = {16'd0, modes_q.red};
			REG_GREEN_MODES:  prdata = {16'd0, modes_q.green};
			REG_YELLOW_MODES: prdata = {16'd0, modes_q.yellow};
			REG_WAIT_TICKS:   prdata = {16'd0, wait_q};
			default:          prdata = '0;
		endcase
	end

	// Every advance must land in an empty or draining result register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |-> !advance)
		else $error("result beat overwritten");

	// A held tick moves on in the cycle the result register frees up.
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !res_valid_q) |-> advance)
		else $error("input register stuck");

	// An advance always produces a result beat in the next cycle.
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("advance without result beat");

endmodule

// ===== sim/tlbc_lamp_checker.sv =====
// Checker for the tower lamp blink controller: follows register writes and input ticks,
// predicts each result beat and compares it with what the block returns.
// Depends on tlbc_pkg, tlbc_item_if and tlbc_result_if.
`timescale 1ns / 1ps

module tlbc_lamp_checker import tlbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tlbc_item_if        item,
	tlbc_result_if      result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending
);

	localparam int WAIT_WIDTH = 16;

	// Shadow copy of the registers and of the blink state.
	modes_t                modes;
	logic [15:0]           wait_len;
	logic [2:0]            phase;
	logic [WAIT_WIDTH:0]   elapsed;
	logic [LAMP_COUNT-1:0] lamps;
	logic [2:0]            shown;

	result_t expected_lamps[$];
	result_t got_beat;
	result_t want_beat;
	result_t next_beat;
	item_t   tick;
	string   lamp_name[LAMP_COUNT];

	initial begin
		lamp_name[LAMP_RED]    = "red_lamp";
		lamp_name[LAMP_YELLOW] = "yellow_lamp";
		lamp_name[LAMP_GREEN]  = "green_lamp";
		lamp_name[LAMP_START]  = "start_lamp";
		lamp_name[LAMP_STOP]   = "stop_lamp";
		lamp_name[LAMP_CLEAR]  = "clear_lamp";
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Counts one tick of a wait phase; true once the count has passed the phase length.
	function automatic logic wait_over();
		if (elapsed != '1)
			elapsed++;
		return elapsed > {1'b0, wait_len};
	endfunction

	function automatic logic mode_level(input logic [TABLE_WIDTH-1:0] mode_bits, input int lamp,
			input logic on);
		logic [1:0] m;
		m = mode_bits[2*shown +: 2];
		case (m)
			MODE_OFF: begin
				return 1'b0;
			end
			MODE_ON: begin
				return 1'b1;
			end
			MODE_FLICKER: begin
				return on;
			end
			default: begin
				return lamps[lamp];
			end
		endcase
	endfunction

	task automatic tick_lamps(input item_t t, output result_t r);
		logic [2:0] p;
		logic       on;
		p = phase;
		if (!t.io_screen) begin
			if (t.run_status == ST_JAM || t.run_status == ST_WARNING) begin
				lamps[LAMP_STOP]  = 1'b1;
				lamps[LAMP_START] = 1'b0;
			end
			if (t.run_status == ST_INIT) begin
				// Chase: even phases light one colour and its switch lamp, odd phases wait.
				if (!p[0]) begin
					lamps[LAMP_RED]    = (p == PH_ON);
					lamps[LAMP_START]  = (p == PH_ON);
					lamps[LAMP_YELLOW] = (p == PH_OFF || p == PH_CHASE_Y2);
					lamps[LAMP_STOP]   = (p == PH_OFF || p == PH_CHASE_Y2);
					lamps[LAMP_GREEN]  = (p == PH_CHASE_G);
					lamps[LAMP_CLEAR]  = (p == PH_CHASE_G);
					elapsed = '0;
					phase = p + 3'd1;
				end else if (wait_over()) begin
					phase = p + 3'd1;
				end
			end else begin
				if (!t.recovery) begin
					if (t.lot_end)
						shown = ST_LOTEND;
					else if (t.lot_empty || t.next_down)
						shown = ST_SELFCHECK;
					else
						shown = t.run_status;
				end
				if (p == PH_ON || p == PH_OFF) begin
					on = (p == PH_ON);
					if (t.recovery) begin
						lamps[LAMP_GREEN] = on;
						lamps[LAMP_START] = on;
					end else begin
						lamps[LAMP_RED]    = mode_level(modes.red, LAMP_RED, on);
						lamps[LAMP_GREEN]  = mode_level(modes.green, LAMP_GREEN, on);
						lamps[LAMP_YELLOW] = mode_level(modes.yellow, LAMP_YELLOW, on);
					end
					elapsed = '0;
					phase = p + 3'd1;
				end else if (p == PH_ON_WAIT || p == PH_OFF_WAIT) begin
					if (wait_over())
						phase = (p == PH_OFF_WAIT) ? PH_ON : PH_OFF;
				end else begin
					// Left over from the chase: restart the blink without touching lamps.
					phase = PH_ON;
				end
			end
		end
		r.lamps = lamps;
		r.shown_status = shown;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes = '0;
			wait_len = WAIT_RESET;
			phase = PH_ON;
			elapsed = '0;
			lamps = '0;
			shown = ST_STOP;
			mismatches = 0;
			expected_lamps.delete();
			pending <= 0;
		end else begin
			// Results lag their ticks, so compare before queuing this edge's tick.
			if (result.valid && result.ready) begin
				got_beat.lamps[LAMP_RED]    = result.red_lamp;
				got_beat.lamps[LAMP_YELLOW] = result.yellow_lamp;
				got_beat.lamps[LAMP_GREEN]  = result.green_lamp;
				got_beat.lamps[LAMP_START]  = result.start_lamp;
				got_beat.lamps[LAMP_STOP]   = result.stop_lamp;
				got_beat.lamps[LAMP_CLEAR]  = result.clear_lamp;
				got_beat.shown_status       = result.shown_status;
				if (expected_lamps.size() == 0) begin
					report_mismatch($sformatf("result beat %b/%0d with no tick outstanding",
						got_beat.lamps, got_beat.shown_status));
				end else begin
					want_beat = expected_lamps.pop_front();
					for (int i = 0; i < LAMP_COUNT; i++)
						if (got_beat.lamps[i] !== want_beat.lamps[i])
							report_mismatch($sformatf("%s got %b, expected %b", lamp_name[i],
								got_beat.lamps[i], want_beat.lamps[i]));
					if (got_beat.shown_status !== want_beat.shown_status)
						report_mismatch($sformatf("shown_status got %0d, expected %0d",
							got_beat.shown_status, want_beat.shown_status));
				end
			end
			if (item.valid && item.ready) begin
				tick.run_status = item.run_status;
				tick.io_screen  = item.io_screen;
				tick.recovery   = item.recovery;
				tick.lot_end    = item.lot_end;
				tick.lot_empty  = item.lot_empty;
				tick.next_down  = item.next_down;
				tick_lamps(tick, next_beat);
				expected_lamps.push_back(next_beat);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RED_MODES: begin
						modes.red = pwdata[15:0];
					end
					REG_GREEN_MODES: begin
						modes.green = pwdata[15:0];
					end
					REG_YELLOW_MODES: begin
						modes.yellow = pwdata[15:0];
					end
					default: begin
						wait_len = pwdata[15:0];
					end
				endcase
			end
			pending <= expected_lamps.size();
		end
	end

endmodule

// ===== sim/tower_lamp_blink_controller_test.sv =====
// Testbench top for the tower lamp blink controller: clock, reset, register writes,
// tick stimulus with random gaps and result stalls, and the final verdict.
// Depends on tlbc_pkg, the two channel interfaces, the block and tlbc_lamp_checker.
`timescale 1ns / 1ps

module tower_lamp_blink_controller_test import tlbc_pkg::*; ();

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          mismatches;
	int          pending;
	bit          gaps_on;
	bit          stalls_on;

	tlbc_item_if   item_ch();
	tlbc_result_if result_ch();

	tower_lamp_blink_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	tlbc_lamp_checker lamp_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: takes every beat except during random stall bursts.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stalls_on && $urandom_range(0, 7) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// Returns at the edge where the beat is taken; valid stays high for a following beat.
	task automatic send_tick(input item_t t);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.run_status <= t.run_status;
		item_ch.io_screen  <= t.io_screen;
		item_ch.recovery   <= t.recovery;
		item_ch.lot_end    <= t.lot_end;
		item_ch.lot_empty  <= t.lot_empty;
		item_ch.next_down  <= t.next_down;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic tick(input logic [2:0] status, input logic io, input logic rec,
			input logic lot_end, input logic lot_empty, input logic next_down);
		send_tick({status, io, rec, lot_end, lot_empty, next_down});
	endtask

	// Stops sending and waits until every outstanding result has come back.
	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_config(input logic [15:0] red, input logic [15:0] green,
			input logic [15:0] yellow, input logic [15:0] wait_len);
		drain();
		write_reg(REG_RED_MODES, red);
		write_reg(REG_GREEN_MODES, green);
		write_reg(REG_YELLOW_MODES, yellow);
		write_reg(REG_WAIT_TICKS, wait_len);
	endtask

	initial begin
		item_t       t;
		item_t       seg;
		int          quota;
		int          sent;
		int          seg_len;
		logic [15:0] wait_len;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.run_status = ST_STOP;
		item_ch.io_screen = 1'b0;
		item_ch.recovery = 1'b0;
		item_ch.lot_end = 1'b0;
		item_ch.lot_empty = 1'b0;
		item_ch.next_down = 1'b0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings first, then every mode with one-tick phases.
		tick(ST_RUN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		load_config(16'hE4E4, 16'h4E1B, 16'h93B1, 16'd0);
		tick(ST_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(ST_STOP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(ST_JAM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(ST_WARNING, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		// Seven chase ticks leave the phase past the blink cycle for the next normal tick.
		repeat (7) tick(ST_INIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(ST_RUN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		repeat (4) tick(ST_RUN, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		tick(ST_RUN, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
		tick(ST_RUN, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		tick(ST_RUN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
		tick(ST_LOCK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(ST_SELFCHECK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(ST_SELFCHECK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);

		// Random rounds, each under its own settings; the last rounds run without idling.
		for (int round = 0; round < 12; round++) begin
			quota = 130;
			if (round == 0) begin
				load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
			end else if (round == 1) begin
				quota = 40;
				load_config(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
			end else begin
				wait_len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15)) :
					16'($urandom_range(0, 4));
				load_config(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
					16'($urandom_range(0, 16'hFFFF)), wait_len);
			end
			sent = 0;
			while (sent < quota) begin
				gaps_on = (round < 9) && ($urandom_range(0, 3) != 0);
				stalls_on = (round < 9) && ($urandom_range(0, 3) != 0);
				// A segment holds one status and flag set for a while so phases can advance.
				seg.run_status = 3'($urandom_range(0, 7));
				seg.io_screen = 1'b0;
				seg.recovery = ($urandom_range(0, 3) == 0);
				seg.lot_end = ($urandom_range(0, 5) == 0);
				seg.lot_empty = ($urandom_range(0, 5) == 0);
				seg.next_down = ($urandom_range(0, 5) == 0);
				seg_len = $urandom_range(1, 40);
				for (int k = 0; k < seg_len && sent < quota; k++) begin
					if ($urandom_range(0, 9) == 0)
						t = item_t'(8'($urandom_range(0, 255)));
					else
						t = seg;
					send_tick(t);
					sent++;
				end
			end
		end

		drain();
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== tower_lamp_blink_controller.f =====
hdl/tlbc_pkg.sv
hdl/tlbc_item_if.sv
hdl/tlbc_result_if.sv
hdl/tlbc_core.sv
hdl/tower_lamp_blink_controller.sv
sim/tlbc_lamp_checker.sv
sim/tower_lamp_blink_controller_test.sv
